/* hw/rtl/rspe_pkg.sv */
// Shared types and constants for the remote switch pulse encoder.
`default_nettype none

package rspe_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_PREAMBLE_TICKS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_TICKS     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_TICKS      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_COUNT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_COUNT      = 3'd4;

    localparam logic [9:0] PREAMBLE_TICKS_RST = 10'd525;
    localparam logic [9:0] ZERO_TICKS_RST     = 10'd120;
    localparam logic [9:0] ONE_TICKS_RST      = 10'd315;
    localparam logic [7:0] REPEAT_COUNT_RST   = 8'd150;
    localparam logic [4:0] BIT_COUNT_RST      = 5'd23;

    // Key and remote ID field widths
    localparam int KEY_W    = 7;
    localparam int REMOTE_W = 16;

    // Waveform phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_PRE  = 2'd1;
    localparam logic [1:0] PH_BIT1 = 2'd2;
    localparam logic [1:0] PH_BIT2 = 2'd3;

    typedef struct packed {
        logic [9:0] preamble_ticks;
        logic [9:0] zero_ticks;
        logic [9:0] one_ticks;
        logic [7:0] repeat_count;
        logic [4:0] bit_count;
    } cfg_t;

    typedef struct packed {
        logic start_req;
        logic [REMOTE_W-1:0] remote_id;
        logic [KEY_W-1:0] key_id;
    } tick_item_t;

    typedef struct packed {
        logic tx_level;
        logic busy_res;
        logic done_res;
    } result_t;

endpackage

`default_nettype wire

/* hw/rtl/rspe_cfg_regs.sv */
// Configuration register file of the pulse encoder.
`default_nettype none

module rspe_cfg_regs
(
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [rspe_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire  [rspe_pkg::CFG_DATA_W-1:0]   cfg_data,
    output rspe_pkg::cfg_t                    cfg
);
    import rspe_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cfg_index)
                REG_PREAMBLE_TICKS: cfg_next.preamble_ticks = cfg_data[9:0];
                REG_ZERO_TICKS:     cfg_next.zero_ticks     = cfg_data[9:0];
                REG_ONE_TICKS:      cfg_next.one_ticks      = cfg_data[9:0];
                REG_REPEAT_COUNT:   cfg_next.repeat_count   = cfg_data[7:0];
                REG_BIT_COUNT:      cfg_next.bit_count      = cfg_data[4:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.preamble_ticks <= PREAMBLE_TICKS_RST;
            cfg_reg.zero_ticks     <= ZERO_TICKS_RST;
            cfg_reg.one_ticks      <= ONE_TICKS_RST;
            cfg_reg.repeat_count   <= REPEAT_COUNT_RST;
            cfg_reg.bit_count      <= BIT_COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rspe_wave.sv */
// Waveform state machine: one tick of pulse timing per step.
`default_nettype none

module rspe_wave
#(
    parameter int COMMAND_BITS = 23
)
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       step,
    input  rspe_pkg::tick_item_t      item,
    input  rspe_pkg::cfg_t            cfg,
    output rspe_pkg::result_t         res
);
    import rspe_pkg::*;

    logic [1:0]              phase_reg, phase_next;
    logic [9:0]              tick_reg, tick_next;
    logic [4:0]              bidx_reg, bidx_next;
    logic [7:0]              frames_reg, frames_next;
    logic [COMMAND_BITS-1:0] cmd_reg, cmd_next;
    logic                    lvl_reg, lvl_next;

    logic [31:0] cmd_wide;
    logic [63:0] cmd_ext;
    logic [5:0]  nb;
    logic [5:0]  nb_m1;
    logic [5:0]  bidx_clip;
    logic [5:0]  pos;
    logic        bit_one;
    logic [9:0]  limit;
    logic        tick_end;
    logic [10:0] tick_inc;
    logic        bit_ev;
    logic        frame_ev;
    logic [5:0]  bidx_inc;

    // Effective bit count saturates at the command width
    assign nb = ({1'b0, cfg.bit_count} > 6'(COMMAND_BITS)) ? 6'(COMMAND_BITS)
                                                            : {1'b0, cfg.bit_count};
    assign nb_m1    = nb - 6'd1;
    assign cmd_wide = {{(32 - REMOTE_W - KEY_W){1'b0}}, item.remote_id, item.key_id};

    always_comb
    begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        bidx_next   = bidx_reg;
        frames_next = frames_reg;
        cmd_next    = cmd_reg;
        lvl_next    = lvl_reg;
        res         = '0;
        bit_ev      = 1'b0;
        frame_ev    = 1'b0;

        // Latch a start only from idle
        if (phase_reg == PH_IDLE && item.start_req)
        begin
            cmd_next    = cmd_wide[COMMAND_BITS-1:0];
            frames_next = (cfg.repeat_count == 8'd0) ? 8'd1 : cfg.repeat_count;
            bidx_next   = '0;
            tick_next   = '0;
            lvl_next    = 1'b0;
            phase_next  = PH_PRE;
        end

        cmd_ext   = 64'(cmd_next);
        bidx_clip = ({1'b0, bidx_next} < nb) ? {1'b0, bidx_next} : nb_m1;
        pos       = nb_m1 - bidx_clip;
        bit_one   = cmd_ext[pos];

        unique case (phase_next)
            PH_PRE:  limit = cfg.preamble_ticks;
            PH_BIT1: limit = bit_one ? cfg.one_ticks : cfg.zero_ticks;
            PH_BIT2: limit = cfg.zero_ticks;
            default: limit = cfg.zero_ticks;
        endcase

        // A span of zero ends on its first tick, like a span of one
        tick_inc = {1'b0, tick_next} + 11'd1;
        tick_end = tick_inc >= {1'b0, limit};

        unique case (phase_next)
            PH_PRE:
            begin
                res.busy_res = 1'b1;
                res.tx_level = 1'b1;
                if (tick_end)
                begin
                    tick_next = '0;
                    lvl_next  = 1'b0;
                    bidx_next = '0;
                    if (nb == 6'd0)
                        frame_ev = 1'b1;
                    else
                        phase_next = PH_BIT1;
                end
                else
                begin
                    tick_next = tick_inc[9:0];
                end
            end
            PH_BIT1:
            begin
                res.busy_res = 1'b1;
                res.tx_level = lvl_next;
                if (tick_end)
                begin
                    tick_next = '0;
                    if (bit_one)
                    begin
                        lvl_next = ~lvl_next;
                        bit_ev   = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_BIT2;
                    end
                end
                else
                begin
                    tick_next = tick_inc[9:0];
                end
            end
            PH_BIT2:
            begin
                res.busy_res = 1'b1;
                res.tx_level = ~lvl_next;
                if (tick_end)
                begin
                    tick_next = '0;
                    bit_ev    = 1'b1;
                end
                else
                begin
                    tick_next = tick_inc[9:0];
                end
            end
            default:
            begin
                res = '0;
            end
        endcase

        // Advance to the next bit, or close the frame after the last one
        bidx_inc = {1'b0, bidx_next} + 6'd1;
        if (bit_ev)
        begin
            bidx_next = bidx_inc[4:0];
            if (bidx_inc >= nb)
                frame_ev = 1'b1;
            else
                phase_next = PH_BIT1;
        end

        if (frame_ev)
        begin
            frames_next = frames_next - 8'd1;
            bidx_next   = '0;
            if (frames_next == 8'd0)
            begin
                phase_next   = PH_IDLE;
                lvl_next     = 1'b0;
                res.done_res = 1'b1;
            end
            else
            begin
                phase_next = PH_PRE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            tick_reg   <= '0;
            bidx_reg   <= '0;
            frames_reg <= '0;
            cmd_reg    <= '0;
            lvl_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            bidx_reg   <= bidx_next;
            frames_reg <= frames_next;
            cmd_reg    <= cmd_next;
            lvl_reg    <= lvl_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/remote_switch_pulse_encoder.sv */
// Top level of the remote switch pulse encoder: item registers and block wiring.
`default_nettype none

// Channel   Handshake               Payload
// --------  ----------------------  ---------------------------------------
// in        in_valid / in_ready     start_req, remote_id, key_id (one tick)
// out       out_valid / out_ready   tx_level, busy_res, done_res
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data (always ready)
//
// Each input item is one timebase tick. It lands in an input register, and
// the waveform step runs as it moves into the result register, so a result
// is on the output port after its item has passed through both registers,
// input register then result register. One item per cycle is sustained;
// the only limit is the output handshake. When out_ready drops, the result
// register holds, the input register fills, and in_ready falls.
// Reset (rst_n low) returns the encoder to idle with a low line and loads
// the default timing registers.

module remote_switch_pulse_encoder
#(
    parameter int COMMAND_BITS = 23
)
(
    input  wire                              clk,
    input  wire                              rst_n,

    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire                              start_req,
    input  wire  [15:0]                      remote_id,
    input  wire  [6:0]                       key_id,

    output logic                             out_valid,
    input  wire                              out_ready,
    output logic                             tx_level,
    output logic                             busy_res,
    output logic                             done_res,

    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [rspe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire  [rspe_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rspe_pkg::*;

    cfg_t       cfg;
    tick_item_t item_reg;
    logic       item_vld_reg;
    result_t    res_comb;
    result_t    res_reg;
    logic       res_vld_reg;
    logic       step;
    logic       in_fire;

    // Move the held item into the result register when that slot frees up
    assign step     = item_vld_reg && (!res_vld_reg || out_ready);
    assign in_ready = !item_vld_reg || step;
    assign in_fire  = in_valid && in_ready;

    rspe_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rspe_wave #(
        .COMMAND_BITS (COMMAND_BITS)
    ) u_wave
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res_comb)
    );

    // Input register: hold the item until the waveform step takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            item_vld_reg <= 1'b1;
        end
        else if (step)
        begin
            item_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.start_req <= start_req;
            item_reg.remote_id <= remote_id;
            item_reg.key_id    <= key_id;
        end
    end

    // Result register: hold until the consumer takes the item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (step)
        begin
            res_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_valid = res_vld_reg;
    assign tx_level  = res_reg.tx_level;
    assign busy_res  = res_reg.busy_res;
    assign done_res  = res_reg.done_res;

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the remote switch pulse encoder: directed table, then random ticks.

module tb;
    import rspe_pkg::*;

    // Width of the command word; must match the parameter of the instance below.
    localparam int CMD_BITS   = 23;
    // Cycle ceiling for the whole run. The slowest correct run needs well under this.
    localparam int LIMIT      = 200000;
    // Random part: one setting per phase, then a run of ticks under it.
    localparam int NUM_PHASES = 11;
    localparam int NUM_ROWS   = 24;

    // Tick samples that can be read straight off the waveform rules.
    localparam result_t R_IDLE     = '{1'b0, 1'b0, 1'b0};
    localparam result_t R_PREAMBLE = '{1'b1, 1'b1, 1'b0};
    localparam result_t R_LAST     = '{1'b1, 1'b1, 1'b1};

    typedef enum bit {ROW_TICK, ROW_WRITE} row_kind_e;
    typedef enum int {SET_SHORT, SET_SLOW, SET_QUICK_FRAMES} setting_mode_e;

    // One row of the directed table. A tick row is sent n times with the same payload;
    // a write row updates one timing register once the encoder has gone quiet.
    typedef struct {
        row_kind_e              kind;
        int                     n;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0]  data;
        logic                   start;
        logic [15:0]            remote;
        logic [6:0]             key;
        bit                     typed;
        result_t                want;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   start_req;
    logic [15:0]            remote_id;
    logic [6:0]             key_id;
    logic                   out_valid;
    logic                   out_ready;
    logic                   tx_level;
    logic                   busy_res;
    logic                   done_res;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    remote_switch_pulse_encoder #(.COMMAND_BITS(CMD_BITS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .start_req (start_req),
        .remote_id (remote_id),
        .key_id    (key_id),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tx_level  (tx_level),
        .busy_res  (busy_res),
        .done_res  (done_res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Waveform predictor: timing registers plus the encoder's own state.
    // ------------------------------------------------------------------
    cfg_t                enc_cfg;
    logic [1:0]          enc_phase;
    int unsigned         enc_ticks;
    int unsigned         enc_bit;
    int unsigned         enc_frames;
    logic [CMD_BITS-1:0] enc_word;
    logic                enc_level;

    // Expected tick samples, oldest first, one per accepted item.
    result_t     samples_due[$];
    result_t     seen;
    result_t     oldest;
    int          err_count;
    int          burst_left;
    int unsigned cycle_count = 0;
    plan_row_t   plan [NUM_ROWS];

    // Bits sent per frame: a bit count above the word width saturates.
    function automatic int unsigned sent_bits();
        return (enc_cfg.bit_count > CMD_BITS) ? CMD_BITS : enc_cfg.bit_count;
    endfunction

    // Advance the tick counter; true (and counter cleared) once the span is used up.
    // A span of zero therefore behaves as one tick.
    function automatic bit span_over(input int unsigned span);
        if (enc_ticks + 1 >= span) begin
            enc_ticks = 0;
            return 1'b1;
        end
        enc_ticks = (enc_ticks + 1) & 10'h3FF;
        return 1'b0;
    endfunction

    // Close a frame; true when it was the last one and the line drops to idle.
    function automatic bit frame_over();
        enc_frames = (enc_frames - 1) & 8'hFF;
        enc_bit = 0;
        if (enc_frames == 0) begin
            enc_phase = PH_IDLE;
            enc_level = 1'b0;
            return 1'b1;
        end
        enc_phase = PH_PRE;
        return 1'b0;
    endfunction

    function automatic bit bit_over();
        enc_bit++;
        if (enc_bit >= sent_bits())
            return frame_over();
        enc_phase = PH_BIT1;
        return 1'b0;
    endfunction

    // One timebase tick: latch a start when idle, then produce the line sample.
    function automatic result_t encode_tick(input logic go, input logic [15:0] remote,
                                            input logic [6:0] key);
        result_t     r;
        int unsigned nb;
        int unsigned pos;
        logic [63:0] word;
        bit          one;
        r = R_IDLE;
        if (enc_phase == PH_IDLE && go) begin
            enc_word   = {remote, key};
            enc_frames = (enc_cfg.repeat_count == 0) ? 1 : enc_cfg.repeat_count;
            enc_bit    = 0;
            enc_ticks  = 0;
            enc_level  = 1'b0;
            enc_phase  = PH_PRE;
        end
        case (enc_phase)
            PH_PRE: begin
                r.busy_res = 1'b1;
                r.tx_level = 1'b1;
                if (span_over(enc_cfg.preamble_ticks)) begin
                    enc_level = 1'b0;
                    enc_bit = 0;
                    if (sent_bits() == 0)
                        r.done_res = frame_over();
                    else
                        enc_phase = PH_BIT1;
                end
            end
            PH_BIT1: begin
                // MSB first; a bit count shrunk mid-frame clamps the position.
                nb   = sent_bits();
                pos  = (nb - 1 - ((enc_bit < nb) ? enc_bit : nb - 1)) & 6'h3F;
                word = 64'(enc_word);
                one  = word[pos];
                r.busy_res = 1'b1;
                r.tx_level = enc_level;
                if (span_over(one ? enc_cfg.one_ticks : enc_cfg.zero_ticks)) begin
                    if (one) begin
                        enc_level = ~enc_level;
                        r.done_res = bit_over();
                    end
                    else begin
                        enc_phase = PH_BIT2;
                    end
                end
            end
            PH_BIT2: begin
                // Second half of a zero bit runs at the inverted level.
                r.busy_res = 1'b1;
                r.tx_level = ~enc_level;
                if (span_over(enc_cfg.zero_ticks))
                    r.done_res = bit_over();
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void set_register(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_PREAMBLE_TICKS: enc_cfg.preamble_ticks = val;
            REG_ZERO_TICKS:     enc_cfg.zero_ticks     = val;
            REG_ONE_TICKS:      enc_cfg.one_ticks      = val;
            REG_REPEAT_COUNT:   enc_cfg.repeat_count   = val[7:0];
            REG_BIT_COUNT:      enc_cfg.bit_count      = val[4:0];
            default: ;
        endcase
    endfunction

    // Pick a register value for a random phase. Bits above the narrow
    // fields carry noise so every data bit toggles.
    function automatic logic [CFG_DATA_W-1:0] pick_setting(input logic [CFG_INDEX_W-1:0] idx,
                                                           input setting_mode_e mode);
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'($urandom);
        case (idx)
            REG_PREAMBLE_TICKS: begin
                if (mode == SET_SLOW)
                    v = 10'h3FF;
                else if (mode == SET_QUICK_FRAMES)
                    v = '0;
                else
                    v = 10'($urandom_range(0, 3));
            end
            REG_ZERO_TICKS, REG_ONE_TICKS: begin
                v = (mode == SET_SLOW) ? 10'h3FF : 10'($urandom_range(0, 3));
            end
            REG_REPEAT_COUNT: begin
                v[7:0] = (mode == SET_SLOW) ? 8'hFF : 8'($urandom_range(0, 3));
            end
            REG_BIT_COUNT: begin
                if (mode == SET_SLOW)
                    v[4:0] = 5'd23;
                else if (mode == SET_QUICK_FRAMES)
                    v[4:0] = 5'd0;
                else if ($urandom_range(0, 3) == 0)
                    v[4:0] = 5'($urandom_range(0, 31));
                else
                    v[4:0] = 5'($urandom_range(0, 8));
            end
            default: ;
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle counter and watchdog.
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Kill the run if the encoder stops moving items.
    initial begin
        wait (cycle_count >= LIMIT);
        $display("tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender side: one tick item per handshake, bursts with random gaps.
    // ------------------------------------------------------------------

    // Send one tick item and record what the line should do on that tick.
    // Hold valid between items of a burst; drop it only for a gap.
    task automatic send_tick(input logic go, input logic [15:0] remote, input logic [6:0] key,
                             input bit typed, input result_t want);
        int      gap;
        result_t due;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        start_req <= go;
        remote_id <= remote;
        key_id    <= key;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        due = encode_tick(go, remote, key);
        samples_due.push_back(typed ? want : due);
        burst_left--;
    endtask

    // Drop valid and wait for every outstanding sample; each tick yields one,
    // so an empty queue means the pipeline is empty.
    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (samples_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        set_register(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver side: runs of ready broken by stalls, sometimes a long clean run.
    // ------------------------------------------------------------------
    initial begin
        int run_len;
        int hold_len;
        out_ready = 1'b0;
        run_len = 0;
        hold_len = 0;
        forever begin
            @(negedge clk);
            if (run_len == 0 && hold_len == 0) begin
                hold_len = $urandom_range(0, 8);
                run_len = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
            end
            if (hold_len > 0) begin
                out_ready <= 1'b0;
                hold_len--;
            end
            else begin
                out_ready <= 1'b1;
                run_len--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare each accepted sample with the oldest expectation.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want) begin
            err_count++;
            $display("%0t: %s mismatch: expected %0b, actual %0b", $time, name, want, got);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            seen = '{tx_level, busy_res, done_res};
            if (samples_due.size() == 0) begin
                err_count++;
                $display("%0t: sample with no tick pending: expected none, actual %b",
                         $time, seen);
            end
            else begin
                oldest = samples_due.pop_front();
                check_field("tx_level", oldest.tx_level, seen.tx_level);
                check_field("busy_res", oldest.busy_res, seen.busy_res);
                check_field("done_res", oldest.done_res, seen.done_res);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    initial begin
        plan_row_t     row;
        setting_mode_e mode;
        int            span;
        bit            go;

        in_valid   = 1'b0;
        start_req  = 1'b0;
        remote_id  = '0;
        key_id     = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        rst_n      = 1'b0;
        err_count  = 0;
        burst_left = 0;

        // Predictor comes out of reset with the default timing registers.
        enc_cfg    = '{PREAMBLE_TICKS_RST, ZERO_TICKS_RST, ONE_TICKS_RST,
                       REPEAT_COUNT_RST, BIT_COUNT_RST};
        enc_phase  = PH_IDLE;
        enc_ticks  = 0;
        enc_bit    = 0;
        enc_frames = 0;
        enc_word   = '0;
        enc_level  = 1'b0;

        // Directed table. Rows with typed = 1 carry a sample read off the rules;
        // the rest go through the predictor.
        plan = '{
            // idle line right after reset
            '{ROW_TICK,    1, REG_PREAMBLE_TICKS, 10'h000, 1'b0, 16'h0000, 7'h00, 1'b1, R_IDLE},
            // start under default timing: first tick is preamble
            '{ROW_TICK,    1, REG_PREAMBLE_TICKS, 10'h000, 1'b1, 16'hFFFF, 7'h7F, 1'b1, R_PREAMBLE},
            // start while busy: ignored, preamble continues
            '{ROW_TICK,    1, REG_PREAMBLE_TICKS, 10'h000, 1'b1, 16'h0000, 7'h00, 1'b1, R_PREAMBLE},
            // zero preamble acts as one tick, zero bits gives preamble-only frames
            '{ROW_WRITE,   0, REG_PREAMBLE_TICKS, 10'h000, 1'b0, 16'h0000, 7'h00, 1'b0, R_IDLE},
            '{ROW_WRITE,   0, REG_BIT_COUNT,      10'h000, 1'b0, 16'h0000, 7'h00, 1'b0, R_IDLE},
            '{ROW_WRITE,   0, REG_REPEAT_COUNT,   10'h000, 1'b0, 16'h0000, 7'h00, 1'b0, R_IDLE},
            // burn through the remaining default frames, one tick each
            '{ROW_TICK,  149, REG_PREAMBLE_TICKS, 10'h000, 1'b0, 16'h0000, 7'h00, 1'b0, R_IDLE},
            '{ROW_TICK,    1, REG_PREAMBLE_TICKS, 10'h000, 1'b0, 16'h0000, 7'h00, 1'b1, R_LAST},
            // start on the tick after done; zero repeat count sends a single frame
            '{ROW_TICK,    1, REG_PREAMBLE_TICKS, 10'h000, 1'b1, 16'h1234, 7'h55, 1'b1, R_LAST},
            '{ROW_TICK,    1, REG_PREAMBLE_TICKS, 10'h000, 1'b0, 16'h0000, 7'h00, 1'b1, R_IDLE},
            // oversized bit count saturates; zero one/zero lengths act as one tick
            '{ROW_WRITE,   0, REG_BIT_COUNT,      10'h01F, 1'b0, 16'h0000, 7'h00, 1'b0, R_IDLE},
            '{ROW_WRITE,   0, REG_ONE_TICKS,      10'h000, 1'b0, 16'h0000, 7'h00, 1'b0, R_IDLE},
            '{ROW_WRITE,   0, REG_ZERO_TICKS,     10'h000, 1'b0, 16'h0000, 7'h00, 1'b0, R_IDLE},
            // all-ones word: every bit toggles the line
            '{ROW_TICK,    1, REG_PREAMBLE_TICKS, 10'h000, 1'b1, 16'hFFFF, 7'h7F, 1'b1, R_PREAMBLE},
            '{ROW_TICK,   23, REG_PREAMBLE_TICKS, 10'h000, 1'b0, 16'h0000, 7'h00, 1'b0, R_IDLE},
            '{ROW_TICK,    1, REG_PREAMBLE_TICKS, 10'h000, 1'b0, 16'h0000, 7'h00, 1'b1, R_IDLE},
            // short frames mixing zero and one bits; noise above the narrow fields
            '{ROW_WRITE,   0, REG_BIT_COUNT,      10'h3E3, 1'b0, 16'h0000, 7'h00, 1'b0, R_IDLE},
            '{ROW_WRITE,   0, REG_ONE_TICKS,      10'h002, 1'b0, 16'h0000, 7'h00, 1'b0, R_IDLE},
            '{ROW_WRITE,   0, REG_ZERO_TICKS,     10'h003, 1'b0, 16'h0000, 7'h00, 1'b0, R_IDLE},
            '{ROW_TICK,    1, REG_PREAMBLE_TICKS, 10'h000, 1'b1, 16'h0000, 7'h02, 1'b0, R_IDLE},
            '{ROW_TICK,   19, REG_PREAMBLE_TICKS, 10'h000, 1'b0, 16'h0000, 7'h00, 1'b0, R_IDLE},
            '{ROW_WRITE,   0, REG_REPEAT_COUNT,   10'h302, 1'b0, 16'h0000, 7'h00, 1'b0, R_IDLE},
            '{ROW_TICK,    1, REG_PREAMBLE_TICKS, 10'h000, 1'b1, 16'h8000, 7'h05, 1'b0, R_IDLE},
            '{ROW_TICK,   29, REG_PREAMBLE_TICKS, 10'h000, 1'b0, 16'h0000, 7'h00, 1'b0, R_IDLE}
        };

        // Hold reset low, then release it on a falling edge.
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table; register writes only with the pipeline empty.
        foreach (plan[i]) begin
            row = plan[i];
            if (row.kind == ROW_WRITE) begin
                quiesce();
                write_register(row.reg_idx, row.data);
            end
            else begin
                repeat (row.n)
                    send_tick(row.start, row.remote, row.key, row.typed, row.want);
            end
        end

        // Random phases. The first uses the longest timings and the largest
        // repeat count; the second runs one-tick frames to drain that long
        // transmission and then churns through many short ones.
        for (int p = 0; p < NUM_PHASES; p++) begin
            mode = (p == 0) ? SET_SLOW : (p == 1) ? SET_QUICK_FRAMES : SET_SHORT;
            span = (p == 0) ? 100 : (p == 1) ? 300 : $urandom_range(40, 75);
            quiesce();
            for (int r = REG_PREAMBLE_TICKS; r <= REG_BIT_COUNT; r++)
                write_register(CFG_INDEX_W'(r), pick_setting(CFG_INDEX_W'(r), mode));
            for (int t = 0; t < span; t++) begin
                // Open each phase with a start; otherwise request now and then,
                // more often where frames are quick.
                if (t == 0)
                    go = 1'b1;
                else if (mode == SET_QUICK_FRAMES)
                    go = $urandom_range(0, 1);
                else
                    go = ($urandom_range(0, 5) == 0);
                send_tick(go, 16'($urandom), 7'($urandom), 1'b0, R_IDLE);
            end
        end

        // Drain, then keep the clock running so the pipeline can show any stray sample.
        quiesce();
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
